>>> src/lccp_pkg.sv
// ----------------------------------------------------------------------------
// lccp_pkg
// Shared constants and types for the coefficient compress and pack pipeline.
// ----------------------------------------------------------------------------
package lccp_pkg;

  localparam int unsigned LANES       = 8;
  localparam int unsigned COEFF_W     = 13;
  localparam int unsigned CANON_W     = 12;
  localparam int unsigned NARROW_BITS = 4;
  localparam int unsigned WIDE_BITS   = 5;
  localparam int unsigned NUM_W       = CANON_W + WIDE_BITS;
  localparam int unsigned QUOT_W      = WIDE_BITS + 1;
  localparam int unsigned PACK_W      = LANES * WIDE_BITS;

  localparam logic [CANON_W-1:0] MODULUS   = 12'd3329;
  localparam logic [NUM_W-1:0]   HALF_Q    = NUM_W'(3329 / 2);

  // floor(n / 3329) == (n * RECIP) >> RECIP_SHIFT for every n below 2^17
  localparam int unsigned        RECIP_W     = 18;
  localparam int unsigned        RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP       = 18'd161271;
  localparam int unsigned        PROD_W      = NUM_W + RECIP_W;

  localparam logic [WIDE_BITS-1:0] NARROW_MASK = 5'd15;
  localparam logic [WIDE_BITS-1:0] WIDE_MASK   = 5'd31;

  localparam logic [2:0] NARROW_BYTES = 3'd4;
  localparam logic [2:0] WIDE_BYTES   = 3'd5;

  typedef logic signed [COEFF_W-1:0]     coeff_t;
  typedef coeff_t      [LANES-1:0]       coeff_vec_t;
  typedef logic [LANES-1:0][CANON_W-1:0] canon_vec_t;
  typedef logic [LANES-1:0][QUOT_W-1:0]  quot_vec_t;

endpackage

>>> src/lccp_lift.sv
// ----------------------------------------------------------------------------
// lccp_lift
// Stage 1: reduce each signed coefficient to its representative 0..q-1.
// ----------------------------------------------------------------------------
module lccp_lift (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                wide_i,
  input  lccp_pkg::coeff_vec_t coeff_i,
  output lccp_pkg::canon_vec_t canon_o,
  output logic                wide_o
);
  import lccp_pkg::*;

  canon_vec_t canon_d, canon_q;
  logic       wide_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic signed [COEFF_W:0] xs;
      logic signed [COEFF_W:0] ys;
      xs = {coeff_i[i][COEFF_W-1], coeff_i[i]};
      // far below zero needs the modulus twice
      if (xs < -14'sd3329) begin
        ys = xs + 14'sd6658;
      end else if (xs < 14'sd0) begin
        ys = xs + 14'sd3329;
      end else if (xs >= 14'sd3329) begin
        ys = xs - 14'sd3329;
      end else begin
        ys = xs;
      end
      canon_d[i] = ys[CANON_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      canon_q <= canon_d;
      wide_q  <= wide_i;
    end
  end

  assign canon_o = canon_q;
  assign wide_o  = wide_q;

endmodule

>>> src/lccp_scale.sv
// ----------------------------------------------------------------------------
// lccp_scale
// Stage 2: rounded scaling by 2^d / q through a reciprocal multiply per lane.
// ----------------------------------------------------------------------------
module lccp_scale (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                wide_i,
  input  lccp_pkg::canon_vec_t canon_i,
  output lccp_pkg::quot_vec_t  quot_o,
  output logic                wide_o
);
  import lccp_pkg::*;

  quot_vec_t quot_d, quot_q;
  logic      wide_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [NUM_W-1:0]  num;
      logic [PROD_W-1:0] prod;
      if (wide_i) begin
        num = {canon_i[i], {WIDE_BITS{1'b0}}};
      end else begin
        num = {1'b0, canon_i[i], {NARROW_BITS{1'b0}}};
      end
      num  = num + HALF_Q;
      prod = PROD_W'(num) * PROD_W'(RECIP);
      quot_d[i] = prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      wide_q <= wide_i;
    end
  end

  assign quot_o = quot_q;
  assign wide_o = wide_q;

endmodule

>>> src/lccp_pack.sv
// ----------------------------------------------------------------------------
// lccp_pack
// Stage 3: wrap each quotient to d bits and pack the lanes little-endian.
// ----------------------------------------------------------------------------
module lccp_pack (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               wide_i,
  input  lccp_pkg::quot_vec_t quot_i,
  output logic [7:0]         byte_0_o,
  output logic [7:0]         byte_1_o,
  output logic [7:0]         byte_2_o,
  output logic [7:0]         byte_3_o,
  output logic [7:0]         byte_4_o,
  output logic [2:0]         byte_count_o
);
  import lccp_pkg::*;

  logic [PACK_W-1:0] packed_d, packed_q;
  logic [2:0]        count_d, count_q;

  always_comb begin
    packed_d = '0;
    for (int i = 0; i < LANES; i++) begin
      logic [WIDE_BITS-1:0] t;
      if (wide_i) begin
        t = quot_i[i][WIDE_BITS-1:0] & WIDE_MASK;
        packed_d[i*WIDE_BITS +: WIDE_BITS] = t;
      end else begin
        t = quot_i[i][WIDE_BITS-1:0] & NARROW_MASK;
        packed_d[i*NARROW_BITS +: NARROW_BITS] = t[NARROW_BITS-1:0];
      end
    end
    count_d = wide_i ? WIDE_BYTES : NARROW_BYTES;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      packed_q <= packed_d;
      count_q  <= count_d;
    end
  end

  assign byte_0_o     = packed_q[7:0];
  assign byte_1_o     = packed_q[15:8];
  assign byte_2_o     = packed_q[23:16];
  assign byte_3_o     = packed_q[31:24];
  assign byte_4_o     = packed_q[39:32];
  assign byte_count_o = count_q;

endmodule

>>> src/lattice_coeff_compress_pack.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack
// Compress eight coefficients mod 3329 to 4 or 5 bits each and pack to bytes.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, coeff_0_i..7_i     | request in
//  out     | out_valid_o, out_stall_i, byte_0_o..4_o,   | request out
//          | byte_count_o                              |
//  cfg     | cfg_we_i, cfg_wdata_i (wide_mode)          | write only
//
// Three register stages (lift, reciprocal multiply, pack); the pack stage is
// the output register. One request per cycle while the output is not stalled.
// Reset clears the stage valid bits and selects narrow mode.
// A stall holds the output stage; upstream stages keep filling bubbles and
// stall only when every stage ahead is full.
// ----------------------------------------------------------------------------
module lattice_coeff_compress_pack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lccp_pkg::coeff_t     coeff_0_i,
  input  lccp_pkg::coeff_t     coeff_1_i,
  input  lccp_pkg::coeff_t     coeff_2_i,
  input  lccp_pkg::coeff_t     coeff_3_i,
  input  lccp_pkg::coeff_t     coeff_4_i,
  input  lccp_pkg::coeff_t     coeff_5_i,
  input  lccp_pkg::coeff_t     coeff_6_i,
  input  lccp_pkg::coeff_t     coeff_7_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           byte_0_o,
  output logic [7:0]           byte_1_o,
  output logic [7:0]           byte_2_o,
  output logic [7:0]           byte_3_o,
  output logic [7:0]           byte_4_o,
  output logic [2:0]           byte_count_o
);
  import lccp_pkg::*;

  localparam int unsigned STAGES = 3;

  logic              wide_q;
  logic [STAGES-1:0] valid_d, valid_q;
  logic [STAGES-1:0] adv;
  coeff_vec_t        coeff;
  canon_vec_t        canon;
  quot_vec_t         quot;
  logic              wide_s1, wide_s2;

  assign coeff = {coeff_7_i, coeff_6_i, coeff_5_i, coeff_4_i,
                  coeff_3_i, coeff_2_i, coeff_1_i, coeff_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
    end else if (cfg_we_i) begin
      wide_q <= cfg_wdata_i;
    end
  end

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    adv[STAGES-1] = !valid_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[STAGES-1];

  lccp_lift u_lift (
    .clk_i   (clk_i),
    .en_i    (adv[0]),
    .wide_i  (wide_q),
    .coeff_i (coeff),
    .canon_o (canon),
    .wide_o  (wide_s1)
  );

  lccp_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (adv[1]),
    .wide_i  (wide_s1),
    .canon_i (canon),
    .quot_o  (quot),
    .wide_o  (wide_s2)
  );

  lccp_pack u_pack (
    .clk_i        (clk_i),
    .en_i         (adv[2]),
    .wide_i       (wide_s2),
    .quot_i       (quot),
    .byte_0_o     (byte_0_o),
    .byte_1_o     (byte_1_o),
    .byte_2_o     (byte_2_o),
    .byte_3_o     (byte_3_o),
    .byte_4_o     (byte_4_o),
    .byte_count_o (byte_count_o)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for lattice_coeff_compress_pack. Groups of eight coefficients are
// pushed through the valid/stall channel in both compression widths. Each
// accepted request is run through a local compress-and-pack predictor. The
// output bytes are checked in order against it, with and without random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lccp_pkg::*;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [2:0] count;
  } packed_bytes_t;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_wdata_i  = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  coeff_t     coeff_0_i    = '0;
  coeff_t     coeff_1_i    = '0;
  coeff_t     coeff_2_i    = '0;
  coeff_t     coeff_3_i    = '0;
  coeff_t     coeff_4_i    = '0;
  coeff_t     coeff_5_i    = '0;
  coeff_t     coeff_6_i    = '0;
  coeff_t     coeff_7_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] byte_0_o;
  logic [7:0] byte_1_o;
  logic [7:0] byte_2_o;
  logic [7:0] byte_3_o;
  logic [7:0] byte_4_o;
  logic [2:0] byte_count_o;

  packed_bytes_t expected_pack_q[$];
  bit            wide_sel       = 1'b0;
  int unsigned   send_gap_pct   = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   mismatch_count = 0;

  lattice_coeff_compress_pack i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coeff_0_i    (coeff_0_i),
    .coeff_1_i    (coeff_1_i),
    .coeff_2_i    (coeff_2_i),
    .coeff_3_i    (coeff_3_i),
    .coeff_4_i    (coeff_4_i),
    .coeff_5_i    (coeff_5_i),
    .coeff_6_i    (coeff_6_i),
    .coeff_7_i    (coeff_7_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_0_o     (byte_0_o),
    .byte_1_o     (byte_1_o),
    .byte_2_o     (byte_2_o),
    .byte_3_o     (byte_3_o),
    .byte_4_o     (byte_4_o),
    .byte_count_o (byte_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Lift each lane to 0..q-1, round to d bits and pack lane 0 lowest.
  function automatic packed_bytes_t compress_group(input coeff_vec_t grp, input bit wide);
    packed_bytes_t res;
    logic [39:0]   bits;
    int            val;
    int            code;
    int            q;
    int unsigned   width;
    int unsigned   mask;
    int unsigned   lane;
    q     = int'(MODULUS);
    width = wide ? WIDE_BITS : NARROW_BITS;
    mask  = wide ? int'(WIDE_MASK) : int'(NARROW_MASK);
    bits  = '0;
    for (lane = 0; lane < LANES; lane++) begin
      val = int'($signed(grp[lane]));
      if (val < 0) val += q;
      if (val < 0) val += q;
      if (val >= q) val -= q;
      code = (((val << width) + q / 2) / q) & mask;
      bits |= 40'(code) << (lane * width);
    end
    res.b0    = bits[7:0];
    res.b1    = bits[15:8];
    res.b2    = bits[23:16];
    res.b3    = bits[31:24];
    res.b4    = wide ? bits[39:32] : 8'd0;
    res.count = wide ? WIDE_BYTES : NARROW_BYTES;
    return res;
  endfunction

  function automatic coeff_vec_t splat(input int v);
    coeff_vec_t grp;
    for (int unsigned k = 0; k < LANES; k++) grp[k] = coeff_t'(v);
    return grp;
  endfunction

  function automatic coeff_t random_coeff();
    int          v;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      v = int'($urandom_range(6656)) - 3328;
    end else if (sel < 90) begin
      // whole 13-bit field, out-of-range values included
      v = int'($urandom_range(8191));
    end else begin
      case ($urandom_range(3))
        0:       v = 3328 - int'($urandom_range(3));
        1:       v = -3328 + int'($urandom_range(3));
        2:       v = 3329 + int'($urandom_range(3));
        default: v = -3329 - int'($urandom_range(3));
      endcase
    end
    return coeff_t'(v);
  endfunction

  function automatic coeff_vec_t random_group();
    coeff_vec_t grp;
    for (int unsigned k = 0; k < LANES; k++) grp[k] = random_coeff();
    return grp;
  endfunction

  // Hold the request until it is taken; valid stays high on return.
  task automatic send_group(input coeff_vec_t grp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coeff_0_i  <= grp[0];
    coeff_1_i  <= grp[1];
    coeff_2_i  <= grp[2];
    coeff_3_i  <= grp[3];
    coeff_4_i  <= grp[4];
    coeff_5_i  <= grp[5];
    coeff_6_i  <= grp[6];
    coeff_7_i  <= grp[7];
    expected_pack_q.push_back(compress_group(grp, wide_sel));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pack_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit wide);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wide;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wide_sel     = wide;
  endtask

  task automatic test_directed_groups(input bit wide);
    coeff_vec_t grp;
    write_mode(wide);
    send_group(splat(0));
    send_group(splat(1));
    send_group(splat(-1));
    send_group(splat(3328));
    send_group(splat(-3328));
    send_group(splat(3329));
    send_group(splat(-4096));
    send_group(splat(4095));
    // lifted twice below -q, mixed with a single lift
    for (int unsigned k = 0; k < LANES; k++) grp[k] = coeff_t'(k[0] ? -3330 : -3329);
    send_group(grp);
    // rounding edges of both code widths
    grp[0] = coeff_t'(104);  grp[1] = coeff_t'(105);
    grp[2] = coeff_t'(52);   grp[3] = coeff_t'(53);
    grp[4] = coeff_t'(3224); grp[5] = coeff_t'(3225);
    grp[6] = coeff_t'(1664); grp[7] = coeff_t'(1665);
    send_group(grp);
    for (int unsigned k = 0; k < LANES; k++) grp[k] = coeff_t'(int'(k) * 400 - 1400);
    send_group(grp);
    for (int unsigned k = 0; k < LANES; k++) grp[k] = k[0] ? 13'h0AAA : 13'h1555;
    send_group(grp);
  endtask

  task automatic test_random_groups(input int unsigned count, input bit wide,
                                    input int unsigned gap, input int unsigned stall);
    write_mode(wide);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    repeat (count) send_group(random_group());
  endtask

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    packed_bytes_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pack_q.size() == 0) begin
        report_mismatch("unexpected result, byte_0", -1, int'(byte_0_o));
      end else begin
        exp_r = expected_pack_q.pop_front();
        if (byte_0_o !== exp_r.b0)
          report_mismatch("byte_0", int'(exp_r.b0), int'(byte_0_o));
        if (byte_1_o !== exp_r.b1)
          report_mismatch("byte_1", int'(exp_r.b1), int'(byte_1_o));
        if (byte_2_o !== exp_r.b2)
          report_mismatch("byte_2", int'(exp_r.b2), int'(byte_2_o));
        if (byte_3_o !== exp_r.b3)
          report_mismatch("byte_3", int'(exp_r.b3), int'(byte_3_o));
        if (byte_4_o !== exp_r.b4)
          report_mismatch("byte_4", int'(exp_r.b4), int'(byte_4_o));
        if (byte_count_o !== exp_r.count)
          report_mismatch("byte_count", int'(exp_r.count), int'(byte_count_o));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct   = 24;
    recv_stall_pct = 54;
    test_directed_groups(1'b0);
    test_directed_groups(1'b1);
    test_random_groups(320, 1'b0, 24, 54);
    test_random_groups(320, 1'b1, 54, 24);
    test_random_groups(150, 1'b0, 0, 0);
    test_random_groups(150, 1'b1, 0, 0);
    wait_idle();
    if (mismatch_count == 0 && expected_pack_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
